>>> sv/aapr_pkg.sv
// Package for the axis-angle point rotator: CORDIC table and fixed-point constants.
// No dependencies.
`timescale 1ns / 1ps
package aapr_pkg;

  localparam int COORD_BITS_DEF    = 32;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int TABLE_LEN         = 24;
  localparam int DEG_HALF_TURN     = 180;
  localparam int TURN_UNITS        = 2 * DEG_HALF_TURN * 64;
  localparam int HALF_UNITS        = TURN_UNITS / 2;
  localparam int QUARTER_UNITS     = TURN_UNITS / 4;
  // CORDIC gain compensation, 0.60725293 in Q2.30
  localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
  localparam logic signed [33:0] ONE_Q30   = 34'sd1073741824;

  function automatic logic signed [33:0] atan_entry(input int idx);
    logic signed [33:0] v;
    case (idx)
      0:  v = 34'sd188743680;
      1:  v = 34'sd111421900;
      2:  v = 34'sd58872272;
      3:  v = 34'sd29884485;
      4:  v = 34'sd15000234;
      5:  v = 34'sd7507429;
      6:  v = 34'sd3754631;
      7:  v = 34'sd1877430;
      8:  v = 34'sd938729;
      9:  v = 34'sd469366;
      10: v = 34'sd234683;
      11: v = 34'sd117342;
      12: v = 34'sd58671;
      13: v = 34'sd29335;
      14: v = 34'sd14668;
      15: v = 34'sd7334;
      16: v = 34'sd3667;
      17: v = 34'sd1833;
      18: v = 34'sd917;
      19: v = 34'sd458;
      20: v = 34'sd229;
      21: v = 34'sd115;
      22: v = 34'sd57;
      23: v = 34'sd29;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

endpackage

>>> sv/aapr_cordic.sv
// Pipelined CORDIC: one micro-rotation per register stage, with stall.
// Depends on aapr_pkg.
`timescale 1ns / 1ps
module aapr_cordic #(
  parameter int STAGES = aapr_pkg::CORDIC_STAGES_DEF,
  parameter int TAGW   = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  logic                     in_vld,
  input  logic signed [33:0]       in_z,
  input  logic                     in_neg,
  input  logic [TAGW-1:0]          in_tag,
  output logic                     out_vld,
  output logic signed [33:0]       out_cos,
  output logic signed [33:0]       out_sin,
  output logic [TAGW-1:0]          out_tag
);
  import aapr_pkg::*;

  localparam int N = (STAGES > TABLE_LEN) ? TABLE_LEN : STAGES;

  logic signed [33:0] x [0:N];
  logic signed [33:0] y [0:N];
  logic signed [33:0] z [0:N];
  logic               neg [0:N];
  logic               vld [0:N];
  logic [TAGW-1:0]    tag [0:N];

  assign x[0]   = CORDIC_X0;
  assign y[0]   = '0;
  assign z[0]   = in_z;
  assign neg[0] = in_neg;
  assign vld[0] = in_vld;
  assign tag[0] = in_tag;

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [33:0] dx, dy;
    assign dx = y[i] >>> i;
    assign dy = x[i] >>> i;
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (adv) begin
        vld[i+1] <= vld[i];
      end
      if (adv) begin
        if (!z[i][33]) begin
          x[i+1] <= x[i] - dx;
          y[i+1] <= y[i] + dy;
          z[i+1] <= z[i] - atan_entry(i);
        end else begin
          x[i+1] <= x[i] + dx;
          y[i+1] <= y[i] - dy;
          z[i+1] <= z[i] + atan_entry(i);
        end
        neg[i+1] <= neg[i];
        tag[i+1] <= tag[i];
      end
    end
  end

  function automatic logic signed [33:0] clamp30(input logic signed [34:0] v);
    if (v > 35'sd1073741824) return ONE_Q30;
    if (v < -35'sd1073741824) return -ONE_Q30;
    return v[33:0];
  endfunction

  logic signed [34:0] xf, yf;
  assign xf = neg[N] ? -$signed({x[N][33], x[N]}) : $signed({x[N][33], x[N]});
  assign yf = neg[N] ? -$signed({y[N][33], y[N]}) : $signed({y[N][33], y[N]});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= vld[N];
    end
    if (adv) begin
      out_cos <= clamp30(xf);
      out_sin <= clamp30(yf);
      out_tag <= tag[N];
    end
  end
endmodule

>>> sv/axis_angle_point_rotator_core.sv
// Top level of the axis-angle point rotator (Rodrigues matrix, CORDIC sin/cos).
// Depends on aapr_pkg and aapr_cordic.
`timescale 1ns / 1ps
// Usage:
//   Input channel in_valid/in_ready carries point_x/y/z (Q16.16), axis_x/y/z
//   (Q2.14, unit length expected) and angle_deg (1/64 degree). Output channel
//   out_valid/out_ready carries rot_x/y/z (Q16.16, saturated) and clipped.
//   One result per input, in order. No state between items.
// Throughput: one item per cycle while the receiver does not stall the output.
// Register stages (CORDIC_STAGES capped at 24): 2 angle reduction,
//   CORDIC_STAGES micro-rotations, 1 clamp, 5 for the matrix terms and the
//   split row products, 1 output.
// Stall: the whole pipeline advances only while the output register is empty
//   or being taken, so a stalled receiver holds every stage and in_ready
//   drops; nothing is lost or repeated.
// Reset: rst (synchronous) clears all valid bits; the pipeline is empty after.
module axis_angle_point_rotator_core #(
  parameter int COORD_BITS    = aapr_pkg::COORD_BITS_DEF,
  parameter int CORDIC_STAGES = aapr_pkg::CORDIC_STAGES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  input  logic signed [COORD_BITS-1:0] point_z,
  input  logic signed [15:0]           axis_x,
  input  logic signed [15:0]           axis_y,
  input  logic signed [15:0]           axis_z,
  input  logic signed [15:0]           angle_deg,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] rot_x,
  output logic signed [COORD_BITS-1:0] rot_y,
  output logic signed [COORD_BITS-1:0] rot_z,
  output logic                         clipped
);
  import aapr_pkg::*;

  localparam int CB    = COORD_BITS;
  localparam int HIW   = (CB > 24) ? CB - 24 : 1;
  localparam int TAGW  = 3 * CB + 48;

  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // ---- stage A: reduce modulo one turn (signal % constant via compare)
  logic               a_vld;
  logic signed [15:0] a_r;
  logic [TAGW-1:0]    a_tag;
  logic signed [16:0] ang_e, r1;
  assign ang_e = 17'(angle_deg);
  // |angle| <= 32768 < 2 turns; two-step truncated remainder then wrap
  always_comb begin
    r1 = ang_e;
    if (r1 >= 17'sd23040) r1 = r1 - 17'sd23040;
    else if (r1 <= -17'sd23040) r1 = r1 + 17'sd23040;
    if (r1 >= 17'sd23040) r1 = r1 - 17'sd23040;
    else if (r1 <= -17'sd23040) r1 = r1 + 17'sd23040;
    if (r1 >= 17'(HALF_UNITS)) r1 = r1 - 17'(TURN_UNITS);
    if (r1 < -17'(HALF_UNITS)) r1 = r1 + 17'(TURN_UNITS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (adv) begin
      a_vld <= in_valid;
    end
    if (adv) begin
      a_r   <= r1[15:0];
      a_tag <= {point_x, point_y, point_z, axis_x, axis_y, axis_z};
    end
  end

  // ---- stage B: fold into a quarter turn
  logic               b_vld, b_neg;
  logic signed [33:0] b_z;
  logic [TAGW-1:0]    b_tag;
  logic signed [16:0] rf;
  logic               nf;
  always_comb begin
    rf = 17'(a_r);
    nf = 1'b0;
    if (rf > 17'(QUARTER_UNITS)) begin
      rf = rf - 17'(HALF_UNITS);
      nf = 1'b1;
    end else if (rf < -17'(QUARTER_UNITS)) begin
      rf = rf + 17'(HALF_UNITS);
      nf = 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (adv) begin
      b_vld <= a_vld;
    end
    if (adv) begin
      b_z   <= 34'(rf) <<< 16;
      b_neg <= nf;
      b_tag <= a_tag;
    end
  end

  logic               c_vld;
  logic signed [33:0] c_cos, c_sin;
  logic [TAGW-1:0]    c_tag;

  aapr_cordic #(.STAGES(CORDIC_STAGES), .TAGW(TAGW)) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_vld  (b_vld),
    .in_z    (b_z),
    .in_neg  (b_neg),
    .in_tag  (b_tag),
    .out_vld (c_vld),
    .out_cos (c_cos),
    .out_sin (c_sin),
    .out_tag (c_tag)
  );

  // unpack tag
  logic signed [CB-1:0] c_p [0:2];
  logic signed [15:0]   c_v [0:2];
  assign c_p[0] = c_tag[TAGW-1 -: CB];
  assign c_p[1] = c_tag[TAGW-1-CB -: CB];
  assign c_p[2] = c_tag[TAGW-1-2*CB -: CB];
  assign c_v[0] = c_tag[47:32];
  assign c_v[1] = c_tag[31:16];
  assign c_v[2] = c_tag[15:0];

  // ---- D: axis products a*b (32b) and w*s products, t, rounded c
  logic                 d_vld;
  logic signed [31:0]   d_vv [0:2][0:2];
  logic signed [49:0]   d_ws [0:2];
  logic signed [34:0]   d_t;
  logic signed [32:0]   d_c4;
  logic signed [CB-1:0] d_p [0:2];
  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else if (adv) begin
      d_vld <= c_vld;
    end
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          d_vv[i][j] <= 32'(c_v[i] * c_v[j]);
        end
        d_ws[i] <= 50'(c_v[i] * c_sin);
        d_p[i]  <= c_p[i];
      end
      d_t  <= 35'(ONE_Q30) - 35'(c_cos);
      d_c4 <= 33'((35'(c_cos) + 35'sd2) >>> 2);
    end
  end

  // ---- E: a*b*t split in two partial products (32 x 18 each)
  logic                 e_vld;
  logic signed [66:0]   e_hi [0:2][0:2];
  logic signed [49:0]   e_lo [0:2][0:2];
  logic signed [33:0]   e_vs [0:2];
  logic signed [32:0]   e_c4;
  logic signed [CB-1:0] e_p [0:2];
  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else if (adv) begin
      e_vld <= d_vld;
    end
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          e_hi[i][j] <= 67'(d_vv[i][j] * $signed(d_t[34:17])) <<< 17;
          e_lo[i][j] <= 50'(d_vv[i][j] * $signed({1'b0, d_t[16:0]}));
        end
        e_vs[i] <= 34'((d_ws[i] + 50'sd32768) >>> 16);
        e_p[i]  <= d_p[i];
      end
      e_c4 <= d_c4;
    end
  end

  // ---- F: matrix terms in Q28
  logic                 f_vld;
  logic signed [39:0]   f_m [0:2][0:2];
  logic signed [CB-1:0] f_p [0:2];
  logic signed [67:0]   prod [0:2][0:2];
  logic signed [39:0]   mb   [0:2][0:2];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod[i][j] = 68'(e_hi[i][j]) + 68'(e_lo[i][j]) + (68'sd1 <<< 29);
        mb[i][j]   = 40'(prod[i][j] >>> 30);
      end
      mb[i][i] = mb[i][i] + 40'(e_c4);
    end
    mb[0][1] = mb[0][1] - 40'(e_vs[2]);
    mb[0][2] = mb[0][2] + 40'(e_vs[1]);
    mb[1][0] = mb[1][0] + 40'(e_vs[2]);
    mb[1][2] = mb[1][2] - 40'(e_vs[0]);
    mb[2][0] = mb[2][0] - 40'(e_vs[1]);
    mb[2][1] = mb[2][1] + 40'(e_vs[0]);
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else if (adv) begin
      f_vld <= e_vld;
    end
    if (adv) begin
      f_m <= mb;
      f_p <= e_p;
    end
  end

  // ---- G: partial products m * p_hi and m * p_lo (split of p at bit 24)
  logic                  g_vld;
  logic signed [HIW+40:0] g_hi [0:2][0:2];
  logic signed [64:0]     g_lo [0:2][0:2];
  always_ff @(posedge clk) begin
    if (rst) begin
      g_vld <= 1'b0;
    end else if (adv) begin
      g_vld <= f_vld;
    end
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          g_hi[i][j] <= (HIW+41)'(f_m[i][j] * $signed(HIW'(f_p[j] >>> 24)));
          g_lo[i][j] <= 65'(f_m[i][j] * $signed({1'b0, 24'(f_p[j])}));
        end
      end
    end
  end

  // ---- H: row sums
  logic               h_vld;
  logic signed [HIW+43:0] h_hi [0:2];
  logic signed [66:0]     h_lo [0:2];
  always_ff @(posedge clk) begin
    if (rst) begin
      h_vld <= 1'b0;
    end else if (adv) begin
      h_vld <= g_vld;
    end
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        h_hi[i] <= (HIW+44)'(g_hi[i][0]) + (HIW+44)'(g_hi[i][1]) + (HIW+44)'(g_hi[i][2]);
        h_lo[i] <= 67'(g_lo[i][0]) + 67'(g_lo[i][1]) + 67'(g_lo[i][2]);
      end
    end
  end

  // ---- I: combine, round, saturate
  localparam int SW = (HIW + 45 > 45) ? HIW + 45 : 45;
  logic signed [SW-1:0] hsum [0:2];
  logic signed [SW-1:0] rv   [0:2];
  logic signed [CB-1:0] sat  [0:2];
  logic [2:0]           clp;
  localparam logic signed [SW-1:0] CMAX = SW'((64'sd1 <<< (CB - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] CMIN = -CMAX - SW'(1);
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      hsum[i] = SW'(h_hi[i]) + SW'(h_lo[i] >>> 24);
      rv[i]   = (hsum[i] + SW'(8)) >>> 4;
      clp[i]  = 1'b0;
      if (rv[i] > CMAX) begin
        sat[i] = CMAX[CB-1:0];
        clp[i] = 1'b1;
      end else if (rv[i] < CMIN) begin
        sat[i] = CMIN[CB-1:0];
        clp[i] = 1'b1;
      end else begin
        sat[i] = rv[i][CB-1:0];
      end
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= h_vld;
    end
    if (adv) begin
      rot_x   <= sat[0];
      rot_y   <= sat[1];
      rot_z   <= sat[2];
      clipped <= |clp;
    end
  end

`ifndef SYNTHESIS
  // a stalled output must hold
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(rot_x) && $stable(clipped))
    else $error("output changed while stalled");
  // ready follows output occupancy
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready mismatch");
  // clipped only with a saturated component
  a_clip: assert property (@(posedge clk) disable iff (rst)
    out_valid && clipped |-> (rot_x == CMAX[CB-1:0] || rot_x == CMIN[CB-1:0] ||
      rot_y == CMAX[CB-1:0] || rot_y == CMIN[CB-1:0] ||
      rot_z == CMAX[CB-1:0] || rot_z == CMIN[CB-1:0]))
    else $error("clipped without saturation");
  // CORDIC output clamp range
  a_cs: assert property (@(posedge clk) disable iff (rst)
    c_vld |-> (c_cos <= ONE_Q30 && c_cos >= -ONE_Q30))
    else $error("cosine out of range");
`endif
endmodule

>>> dv/axis_angle_point_rotator_core_tb.sv
// Self-checking bench for axis_angle_point_rotator_core: directed rows, then
// random points, axes and angles under varied valid/ready idling.
// Depends on aapr_pkg and the rotator RTL.
`timescale 1ns / 1ps
module axis_angle_point_rotator_core_tb;
  import aapr_pkg::*;

  typedef struct {
    logic signed [31:0] x, y, z;
    logic               clip;
  } rot_t;

  typedef struct {
    logic signed [31:0] px, py, pz;
    logic signed [15:0] ax, ay, az, ang;
    bit                 typed;
    rot_t               exp_rot;
  } stim_t;

  localparam longint ATAN_Q22 [24] = '{
    188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
    3754631, 1877430, 938729, 469366, 234683, 117342,
    58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29};
  localparam logic signed [15:0] AX1 = 16'sd16384;

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0, clipped;
  logic signed [31:0] point_x = 0, point_y = 0, point_z = 0, rot_x, rot_y, rot_z;
  logic signed [15:0] axis_x = 0, axis_y = 0, axis_z = 0, angle_deg = 0;

  rot_t expected_rots[$];
  stim_t directed_rows[$];
  int errors = 0, n_results = 0, n_clipped = 0, stall_pct = 0, idle_pct = 0;
  bit hold_request = 0;

  always #10 clk = ~clk;

  axis_angle_point_rotator_core DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z), .angle_deg(angle_deg),
    .out_valid(out_valid), .out_ready(out_ready),
    .rot_x(rot_x), .rot_y(rot_y), .rot_z(rot_z), .clipped(clipped));

  function automatic longint round_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  // Rodrigues rotation with CORDIC cos/sin, bit exact to the block.
  function automatic rot_t rotate_point(stim_t st);
    longint r, x, y, z, dx, dy, c, s, t, hi, lo, acc;
    longint p[3], v[3], vs[3], m[3][3];
    bit neg;
    rot_t res;
    p = '{st.px, st.py, st.pz};
    v = '{st.ax, st.ay, st.az};
    neg = 0;
    r = longint'(st.ang) % TURN_UNITS;
    if (r >= HALF_UNITS) r -= TURN_UNITS;
    if (r < -HALF_UNITS) r += TURN_UNITS;
    if (r > QUARTER_UNITS) begin r -= HALF_UNITS; neg = 1; end
    if (r < -QUARTER_UNITS) begin r += HALF_UNITS; neg = 1; end
    x = 652032874; y = 0; z = r * 65536;
    for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_Q22[i];
      end else begin
        x += dx; y -= dy; z += ATAN_Q22[i];
      end
    end
    if (neg) begin x = -x; y = -y; end
    c = (x > (64'sd1 << 30)) ? (64'sd1 << 30) : (x < -(64'sd1 << 30)) ? -(64'sd1 << 30) : x;
    s = (y > (64'sd1 << 30)) ? (64'sd1 << 30) : (y < -(64'sd1 << 30)) ? -(64'sd1 << 30) : y;
    t = (64'sd1 << 30) - c;
    for (int i = 0; i < 3; i++) vs[i] = round_shift(v[i] * s, 16);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) m[i][j] = round_shift(v[i] * v[j] * t, 30);
    for (int i = 0; i < 3; i++) m[i][i] += round_shift(c, 2);
    m[0][1] -= vs[2]; m[0][2] += vs[1];
    m[1][0] += vs[2]; m[1][2] -= vs[0];
    m[2][0] -= vs[1]; m[2][1] += vs[0];
    res.clip = 0;
    for (int i = 0; i < 3; i++) begin
      hi = 0; lo = 0;
      // split keeps the products inside 64 bits
      for (int j = 0; j < 3; j++) begin
        hi += m[i][j] * (p[j] >>> 24);
        lo += m[i][j] * (p[j] & 64'hFF_FFFF);
      end
      acc = (hi + (lo >>> 24) + 8) >>> 4;
      if (acc > 64'sd2147483647) begin acc = 64'sd2147483647; res.clip = 1; end
      if (acc < -64'sd2147483648) begin acc = -64'sd2147483648; res.clip = 1; end
      case (i)
        0: res.x = acc[31:0];
        1: res.y = acc[31:0];
        default: res.z = acc[31:0];
      endcase
    end
    return res;
  endfunction

  function automatic stim_t make_row(logic signed [31:0] px, py, pz,
                                     logic signed [15:0] ax, ay, az, ang);
    stim_t st;
    st.px = px; st.py = py; st.pz = pz;
    st.ax = ax; st.ay = ay; st.az = az; st.ang = ang;
    st.typed = (px == 0 && py == 0 && pz == 0);
    st.exp_rot = '{0, 0, 0, 0};  // zero point stays at the origin
    return st;
  endfunction

  function automatic stim_t random_item();
    stim_t st;
    real th, ph;
    int sel;
    sel = $urandom_range(9);
    st.px = $urandom; st.py = $urandom; st.pz = $urandom;
    if (sel < 5) begin
      // moderate points: mostly unclipped results
      st.px = $signed(st.px) >>> $urandom_range(30, 4);
      st.py = $signed(st.py) >>> $urandom_range(30, 4);
      st.pz = $signed(st.pz) >>> $urandom_range(30, 4);
    end else if (sel == 5) begin
      st.px = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
    end
    if ($urandom_range(4) == 0) begin
      st.ax = 16'($urandom); st.ay = 16'($urandom); st.az = 16'($urandom);
    end else begin
      th = $urandom_range(62831) / 10000.0;
      ph = $urandom_range(31415) / 10000.0;
      st.ax = 16'($rtoi(AX1 * $sin(ph) * $cos(th)));
      st.ay = 16'($rtoi(AX1 * $sin(ph) * $sin(th)));
      st.az = 16'($rtoi(AX1 * $cos(ph)));
    end
    if ($urandom_range(9) < 3) st.ang = 16'($urandom);
    else st.ang = 16'($signed($urandom_range(2 * TURN_UNITS)) - TURN_UNITS);
    st.typed = 0;
    return st;
  endfunction

  task automatic send_item(stim_t st);
    if ($urandom_range(99) < idle_pct) begin
      @(negedge clk) in_valid = 0;
      while ($urandom_range(99) < idle_pct) @(negedge clk);
    end
    @(negedge clk);
    point_x = st.px; point_y = st.py; point_z = st.pz;
    axis_x = st.ax; axis_y = st.ay; axis_z = st.az; angle_deg = st.ang;
    in_valid = 1;
    do @(posedge clk); while (!in_ready);
    expected_rots.insert(expected_rots.size(), st.typed ? st.exp_rot : rotate_point(st));
  endtask

  task automatic drain();
    @(negedge clk) in_valid = 0;
    while (expected_rots.size() != 0) @(posedge clk);
  endtask

  // receiver: random stalls, plus one long hold-off per request
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request && hold_left == 0) begin
        hold_left = 300;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready = 0;
      end else begin
        out_ready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    rot_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_rots.size() == 0) begin
        $error("result with nothing expected: %0d %0d %0d", rot_x, rot_y, rot_z);
        errors++;
      end else begin
        e = expected_rots.pop_front();
        n_results++;
        if (clipped) n_clipped++;
        if (rot_x !== e.x) begin $error("rot_x exp %0d got %0d", e.x, rot_x); errors++; end
        if (rot_y !== e.y) begin $error("rot_y exp %0d got %0d", e.y, rot_y); errors++; end
        if (rot_z !== e.z) begin $error("rot_z exp %0d got %0d", e.z, rot_z); errors++; end
        if (clipped !== e.clip) begin
          $error("clipped exp %0b got %0b", e.clip, clipped); errors++;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("axis_angle_point_rotator_core: mismatch");
    $finish;
  end

  initial begin
    int stall_tab[4], idle_tab[4];
    stall_tab = '{0, 0, 79, 6};
    idle_tab = '{0, 79, 0, 6};
    directed_rows = '{
      make_row(0, 0, 0, AX1, 0, 0, 0),
      make_row(0, 0, 0, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff),
      make_row(0, 0, 0, -AX1, 0, 0, 16'sh8000),
      make_row(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 0, 0, AX1, 5760),
      make_row(32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 0, 0, 11520),
      make_row(32'sh80000000, 32'sh7fffffff, 32'sh80000000, AX1, 0, 0, -11520),
      make_row(32'h00010000, 0, 0, 0, 0, AX1, 5760),
      make_row(32'h00010000, 0, 0, 0, 0, AX1, 5761),
      make_row(32'h00010000, 0, 0, 0, 0, AX1, -5761),
      make_row(0, 32'h00010000, 0, AX1, 0, 0, 23040),
      make_row(0, 32'h00010000, 0, AX1, 0, 0, -23040),
      make_row(0, 0, 32'h00010000, 0, AX1, 0, 16'sh7fff),
      make_row(0, 0, 32'h00010000, 0, -AX1, 0, 16'sh8000),
      make_row(32'h12345678, -32'sh2345678, 32'h0abcdef0, 9459, 9459, 9459, 3840),
      make_row(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 16'sh7fff, 16'sh7fff,
               16'sh7fff, 1000),
      make_row(32'sh80000000, 0, 0, 16'sh8000, 16'sh8000, 16'sh8000, -1000),
      make_row(1, -1, 1, 0, AX1, 0, 1),
      make_row(-1, 1, -1, 0, 0, -AX1, -1),
      make_row(32'h00020000, 32'h00030000, 32'h00040000, 0, 11585, 11585, 17280)};
    repeat (6) @(posedge clk);
    @(negedge clk) rst = 0;
    foreach (directed_rows[k]) send_item(directed_rows[k]);
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      stall_pct = stall_tab[ph];
      idle_pct = idle_tab[ph];
      for (int k = 0; k < 362; k++) begin
        // long receiver hold-off while items keep coming
        if (ph == 0 && k == 40) hold_request = 1;
        if (k == 200) drain();
        send_item(random_item());
      end
      drain();
    end
    repeat (40) @(posedge clk);
    $display("checked %0d results (%0d clipped) over four idling phases",
             n_results, n_clipped);
    if (errors == 0 && expected_rots.size() == 0)
      $display("axis_angle_point_rotator_core: match");
    else
      $display("axis_angle_point_rotator_core: mismatch");
    $finish;
  end

endmodule

>>> filelist.f
sv/aapr_pkg.sv
sv/aapr_cordic.sv
sv/axis_angle_point_rotator_core.sv
dv/axis_angle_point_rotator_core_tb.sv
